[src/pcg_pkg.sv]
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types, constants and helper functions of the color gradient block.
// ----------------------------------------------------------------------------
package pcg_pkg;

    // field widths
    localparam int POS_W   = 16;
    localparam int COLOR_W = 20;
    localparam int CH_W    = 7;
    localparam int Q1_W    = 14;
    localparam int NUM_W   = 23;
    localparam int DEN_W   = 16;

    // decimal packing weights and channel limit
    localparam int DEC_R  = 10000;
    localparam int DEC_G  = 100;
    localparam int CH_MAX = 99;

    // floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2**20
    localparam logic [20:0] RECIP_100   = 21'd1342178;
    localparam int          RECIP_SHIFT = 27;
    localparam int          PROD_W      = 41;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // one breakpoint as held in the table, color already split into channels
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [CH_W-1:0]         r;
        logic [CH_W-1:0]         g;
        logic [CH_W-1:0]         b;
    } point_t;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [CH_W-1:0]   quot;
    } div_rsp_t;

    // quotient by 100 through a reciprocal multiply
    function automatic logic [Q1_W-1:0] div100(input logic [COLOR_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(RECIP_100);
        return prod[PROD_W-1 -: Q1_W];
    endfunction

    // keep a channel within 0..99
    function automatic logic [CH_W-1:0] clamp_ch(input logic [CH_W-1:0] c);
        return (c > CH_W'(CH_MAX)) ? CH_W'(CH_MAX) : c;
    endfunction

    // repack three channels as r*10000 + g*100 + b
    function automatic logic [COLOR_W-1:0] pack_rgb(input logic [CH_W-1:0] r,
                                                   input logic [CH_W-1:0] g,
                                                   input logic [CH_W-1:0] b);
        return COLOR_W'(r) * COLOR_W'(DEC_R) + COLOR_W'(g) * COLOR_W'(DEC_G)
               + COLOR_W'(b);
    endfunction

endpackage

[src/pcg_div.sv]
// ----------------------------------------------------------------------------
// pcg_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// stay below 128, so seven steps cover it.
// ----------------------------------------------------------------------------
module pcg_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  pcg_pkg::div_req_t  req,
    output pcg_pkg::div_rsp_t  rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [2:0]                  bit_reg;
    logic [pcg_pkg::NUM_W-1:0]   rem_reg;
    logic [pcg_pkg::DEN_W-1:0]   den_reg;
    logic [pcg_pkg::CH_W-1:0]    quot_reg;

    logic [pcg_pkg::NUM_W-1:0]   shifted;
    logic                        fits;

    // trial subtract of the shifted divisor
    assign shifted = pcg_pkg::NUM_W'(den_reg) << bit_reg;
    assign fits    = (rem_reg >= shifted);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == 3'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.num;
            den_reg  <= req.den;
            bit_reg  <= 3'(pcg_pkg::CH_W - 1);
            quot_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg           <= rem_reg - shifted;
                quot_reg[bit_reg] <= 1'b1;
            end
            bit_reg <= bit_reg - 3'd1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

[src/piecewise_color_gradient.sv]
// ----------------------------------------------------------------------------
// piecewise_color_gradient
// Maps a signed value to a decimal packed color by linear interpolation
// between breakpoints held in a small table.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the result register lets the next item in
// while a result waits. A load holds s_ready low through S_LD_Q1, S_LD_Q2 and
// S_LD_WR after its acceptance: two reciprocal multiplies split the color
// into channels before the table write. A query reads the table one entry
// per cycle through its single read port. A hit that lands exactly on a
// breakpoint goes from S_SCAN through S_PACK and S_OUT to the result
// register; any other hit first passes S_MUL and S_DIV for each of the three
// channels in turn, in the shared 7-step divider. A query that finds no
// segment scans all n entries, n being points_in_use saturated to MAX_POINTS,
// before S_OUT (no scan when fewer than two points are in use). S_OUT holds a
// result while a previous result still waits for m_ready. The table has no
// reset; a slot must be loaded before a query reaches it.
// ----------------------------------------------------------------------------
module piecewise_color_gradient #(
    parameter int MAX_POINTS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [3:0]                         cfg_wr_data,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_kind,
    input  logic [2:0]                         s_point_index,
    input  logic signed [pcg_pkg::POS_W-1:0]   s_point_position,
    input  logic [pcg_pkg::COLOR_W-1:0]        s_point_color,
    input  logic signed [pcg_pkg::POS_W-1:0]   s_query_value,
    // result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pcg_pkg::COLOR_W-1:0]        m_color,
    output logic                               m_in_range
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LD_Q1, S_LD_Q2, S_LD_WR, S_SCAN, S_MUL, S_DIV, S_PACK, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [3:0]                        pu_reg;
    logic [6:0]                        pu_wide;
    logic [6:0]                        cnt_wide;
    logic [CNT_W-1:0]                  count;

    // breakpoint table
    pcg_pkg::point_t                   mem [MAX_POINTS];
    pcg_pkg::point_t                   rd_data_reg;
    pcg_pkg::point_t                   wr_data;
    logic [IDX_W-1:0]                  rd_addr;
    logic                              mem_we;

    // load path
    logic [pcg_pkg::COLOR_W-1:0]       ld_color_reg;
    logic signed [pcg_pkg::POS_W-1:0]  ld_pos_reg;
    logic [IDX_W-1:0]                  ld_slot_reg;
    logic                              ld_ok_reg;
    logic [pcg_pkg::Q1_W-1:0]          q1_reg;
    logic [pcg_pkg::CH_W-1:0]          q2_reg;
    logic [pcg_pkg::CH_W-1:0]          lb_reg;
    logic [6:0]                        slot_wide;
    logic [pcg_pkg::COLOR_W-1:0]       dv_in;
    logic [pcg_pkg::Q1_W-1:0]          dv_q;
    logic [pcg_pkg::COLOR_W-1:0]       blue_full;
    logic [pcg_pkg::Q1_W-1:0]          green_full;

    // query path
    logic signed [pcg_pkg::POS_W-1:0]  v_reg;
    pcg_pkg::point_t                   prev_reg;
    logic [CNT_W-1:0]                  k_reg;
    logic [CNT_W-1:0]                  k_plus1;
    logic                              hit;
    logic signed [pcg_pkg::POS_W:0]    a_full;
    logic signed [pcg_pkg::POS_W:0]    wb_full;
    logic signed [pcg_pkg::POS_W:0]    den_full;
    logic [pcg_pkg::DEN_W-1:0]         a_reg;
    logic [pcg_pkg::DEN_W-1:0]         wb_reg;
    logic [pcg_pkg::DEN_W-1:0]         den_reg;
    logic [pcg_pkg::CH_W-1:0]          c1_reg [3];
    logic [pcg_pkg::CH_W-1:0]          c2_reg [3];
    logic [pcg_pkg::CH_W-1:0]          res_reg [3];
    logic [1:0]                        ch_reg;
    logic [pcg_pkg::NUM_W-1:0]         num;

    // result register
    logic                              m_valid_reg;
    logic [pcg_pkg::COLOR_W-1:0]       m_color_reg;
    logic                              m_in_range_reg;
    logic [pcg_pkg::COLOR_W-1:0]       res_color_reg;
    logic                              res_in_range_reg;

    pcg_pkg::div_req_t                 div_req;
    pcg_pkg::div_rsp_t                 div_rsp;

    // points in use, saturated to the table depth
    assign pu_wide  = 7'(pu_reg);
    assign cnt_wide = (pu_wide > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : pu_wide;
    assign count    = cnt_wide[CNT_W-1:0];

    // handshake
    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_color    = m_color_reg;
    assign m_in_range = m_in_range_reg;

    // shared divide-by-100 for channel extraction
    assign dv_in      = (state_reg == S_LD_Q1) ? ld_color_reg
                                               : pcg_pkg::COLOR_W'(q1_reg);
    assign dv_q       = pcg_pkg::div100(dv_in);
    assign blue_full  = ld_color_reg
                        - pcg_pkg::COLOR_W'(q1_reg) * pcg_pkg::COLOR_W'(pcg_pkg::DEC_G);
    assign green_full = q1_reg
                        - pcg_pkg::Q1_W'(q2_reg) * pcg_pkg::Q1_W'(pcg_pkg::DEC_G);
    assign slot_wide  = 7'(s_point_index);

    // table write data
    always_comb begin
        wr_data.pos = ld_pos_reg;
        wr_data.r   = (q2_reg >= pcg_pkg::CH_W'(pcg_pkg::DEC_G))
                      ? q2_reg - pcg_pkg::CH_W'(pcg_pkg::DEC_G) : q2_reg;
        wr_data.g   = green_full[pcg_pkg::CH_W-1:0];
        wr_data.b   = lb_reg;
    end

    assign mem_we  = (state_reg == S_LD_WR) && ld_ok_reg;
    assign k_plus1 = k_reg + CNT_W'(1);
    assign rd_addr = (state_reg == S_SCAN) ? k_plus1[IDX_W-1:0] : '0;

    // breakpoint table, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ld_slot_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // segment test against the previous and current entry
    assign hit      = (prev_reg.pos <= v_reg) && (v_reg <= rd_data_reg.pos);
    assign a_full   = (pcg_pkg::POS_W+1)'(rd_data_reg.pos) - (pcg_pkg::POS_W+1)'(v_reg);
    assign wb_full  = (pcg_pkg::POS_W+1)'(v_reg) - (pcg_pkg::POS_W+1)'(prev_reg.pos);
    assign den_full = (pcg_pkg::POS_W+1)'(rd_data_reg.pos)
                      - (pcg_pkg::POS_W+1)'(prev_reg.pos);

    // weighted channel sum fed to the divider
    assign num = pcg_pkg::NUM_W'(c1_reg[ch_reg]) * pcg_pkg::NUM_W'(a_reg)
               + pcg_pkg::NUM_W'(c2_reg[ch_reg]) * pcg_pkg::NUM_W'(wb_reg);

    assign div_req.start = (state_reg == S_MUL);
    assign div_req.num   = num;
    assign div_req.den   = den_reg;

    pcg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer with registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pu_reg         <= 4'd2;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pu_reg <= cfg_wr_data;
            end
            // the output state decides on its own whether the register refills
            if (m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_kind == pcg_pkg::KIND_LOAD) begin
                            ld_color_reg <= s_point_color;
                            ld_pos_reg   <= s_point_position;
                            ld_slot_reg  <= slot_wide[IDX_W-1:0];
                            ld_ok_reg    <= (slot_wide < 7'(MAX_POINTS));
                            state_reg    <= S_LD_Q1;
                        end else begin
                            v_reg <= s_query_value;
                            k_reg <= '0;
                            if (count < CNT_W'(2)) begin
                                res_color_reg    <= '0;
                                res_in_range_reg <= 1'b0;
                                state_reg        <= S_OUT;
                            end else begin
                                state_reg <= S_SCAN;
                            end
                        end
                    end
                end
                S_LD_Q1: begin
                    q1_reg    <= dv_q;
                    state_reg <= S_LD_Q2;
                end
                S_LD_Q2: begin
                    q2_reg    <= dv_q[pcg_pkg::CH_W-1:0];
                    lb_reg    <= blue_full[pcg_pkg::CH_W-1:0];
                    state_reg <= S_LD_WR;
                end
                S_LD_WR: begin
                    state_reg <= S_IDLE;
                end
                S_SCAN: begin
                    if (k_reg == '0) begin
                        prev_reg <= rd_data_reg;
                        k_reg    <= k_plus1;
                    end else if (hit) begin
                        a_reg     <= a_full[pcg_pkg::DEN_W-1:0];
                        wb_reg    <= wb_full[pcg_pkg::DEN_W-1:0];
                        den_reg   <= den_full[pcg_pkg::DEN_W-1:0];
                        c1_reg[0] <= prev_reg.r;
                        c1_reg[1] <= prev_reg.g;
                        c1_reg[2] <= prev_reg.b;
                        c2_reg[0] <= rd_data_reg.r;
                        c2_reg[1] <= rd_data_reg.g;
                        c2_reg[2] <= rd_data_reg.b;
                        ch_reg    <= 2'd0;
                        // exact hit on a breakpoint skips the divider
                        if (v_reg == prev_reg.pos) begin
                            res_reg[0] <= prev_reg.r;
                            res_reg[1] <= prev_reg.g;
                            res_reg[2] <= prev_reg.b;
                            state_reg  <= S_PACK;
                        end else if (v_reg == rd_data_reg.pos) begin
                            res_reg[0] <= rd_data_reg.r;
                            res_reg[1] <= rd_data_reg.g;
                            res_reg[2] <= rd_data_reg.b;
                            state_reg  <= S_PACK;
                        end else begin
                            state_reg <= S_MUL;
                        end
                    end else if (k_plus1 == count) begin
                        res_color_reg    <= '0;
                        res_in_range_reg <= 1'b0;
                        state_reg        <= S_OUT;
                    end else begin
                        prev_reg <= rd_data_reg;
                        k_reg    <= k_plus1;
                    end
                end
                S_MUL: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        res_reg[ch_reg] <= pcg_pkg::clamp_ch(div_rsp.quot);
                        if (ch_reg == 2'd2) begin
                            state_reg <= S_PACK;
                        end else begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_PACK: begin
                    res_color_reg    <= pcg_pkg::pack_rgb(res_reg[0], res_reg[1],
                                                          res_reg[2]);
                    res_in_range_reg <= 1'b1;
                    state_reg        <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_color_reg    <= res_color_reg;
                        m_in_range_reg <= res_in_range_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // divider answers only while a channel is being divided
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // a new result item appears only from the output state
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result item raised outside the output state");

    // the scan never runs past the points in use
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> k_reg < count)
        else $error("segment scan ran past the points in use");

endmodule
